// File: rtl/core/xxt_pkg.sv
// Shared types, constants and helpers for the XXTEA block cipher unit.
`default_nettype none

package xxt_pkg;

    localparam int          DEFAULT_MAX_WORDS = 64;
    localparam int          WORD_W            = 32;
    localparam int          ROUND_W           = 6;
    localparam int          LEN_W             = 11;
    localparam int          CFG_IDX_W         = 3;
    localparam logic [31:0] TEA_DELTA         = 32'h9E37_79B9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd4;

    typedef enum logic [2:0] {
        DP_IDLE,
        DP_INIT_A,
        DP_INIT_B,
        DP_INIT_C,
        DP_STEP,
        DP_DRAIN
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   store;
    } dp_cmd_t;

    typedef struct packed {
        logic steps_done;
        logic drain_done;
    } dp_stat_t;

    // 6 + 52/n for a block of n words (n >= 1)
    function automatic logic [ROUND_W-1:0] rounds_for(input logic [LEN_W-1:0] n);
        logic [ROUND_W-1:0] q;
        if (n == LEN_W'(1))       q = 6'd52;
        else if (n == LEN_W'(2))  q = 6'd26;
        else if (n == LEN_W'(3))  q = 6'd17;
        else if (n == LEN_W'(4))  q = 6'd13;
        else if (n == LEN_W'(5))  q = 6'd10;
        else if (n == LEN_W'(6))  q = 6'd8;
        else if (n == LEN_W'(7))  q = 6'd7;
        else if (n == LEN_W'(8))  q = 6'd6;
        else if (n <= LEN_W'(10)) q = 6'd5;
        else if (n <= LEN_W'(13)) q = 6'd4;
        else if (n <= LEN_W'(17)) q = 6'd3;
        else if (n <= LEN_W'(26)) q = 6'd2;
        else if (n <= LEN_W'(52)) q = 6'd1;
        else                      q = 6'd0;
        return q + 6'd6;
    endfunction

    // Standard XXTEA MX mixing term
    function automatic logic [WORD_W-1:0] mx(input logic [WORD_W-1:0] z,
                                             input logic [WORD_W-1:0] y,
                                             input logic [WORD_W-1:0] sum,
                                             input logic [WORD_W-1:0] k);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
        b = (sum ^ y) + (k ^ z);
        return a ^ b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/xxt_ctrl.sv
// Sequencing state machine: load, setup, round steps and result drain.
`default_nettype none

module xxt_ctrl import xxt_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    input  wire logic     s_is_last,
    output logic          s_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT_A,
        ST_INIT_B,
        ST_INIT_C,
        ST_RUN,
        ST_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_ready_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid && s_ready_reg && s_is_last) state_next = ST_INIT_A;
            end
            ST_INIT_A: state_next = ST_INIT_B;
            ST_INIT_B: state_next = ST_INIT_C;
            ST_INIT_C: state_next = ST_RUN;
            ST_RUN: begin
                if (stat.steps_done) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (stat.drain_done) state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_LOAD);
        end
    end

    always_comb begin
        cmd.store = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                cmd.op    = DP_IDLE;
                cmd.store = s_valid && s_ready_reg;
            end
            ST_INIT_A: cmd.op = DP_INIT_A;
            ST_INIT_B: cmd.op = DP_INIT_B;
            ST_INIT_C: cmd.op = DP_INIT_C;
            ST_RUN:    cmd.op = DP_STEP;
            ST_DRAIN:  cmd.op = DP_DRAIN;
            default:   cmd.op = DP_IDLE;
        endcase
    end

    assign s_ready = s_ready_reg;

endmodule

`default_nettype wire

// File: rtl/core/xxt_datapath.sv
// Word buffer, XXTEA mixing step, round counters and output register.
`default_nettype none

module xxt_datapath import xxt_pkg::*; #(
    parameter int MAX_WORDS = DEFAULT_MAX_WORDS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire dp_cmd_t                 cmd,
    output dp_stat_t                     stat,
    input  wire logic [WORD_W-1:0]       in_word,
    input  wire logic [3:0][WORD_W-1:0]  key,
    input  wire logic                    decrypt,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [WORD_W-1:0]            m_word,
    output logic                         m_last
);

    localparam int CNT_W  = $clog2(MAX_WORDS + 1);
    localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

    logic [WORD_W-1:0] mem [MAX_WORDS];

    logic [WORD_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [WORD_W-1:0]  wr_data;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pend_reg, pend_next;
    logic               m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0]  pos_reg, pos_next;
    logic [ADDR_W-1:0]  nbr_reg, nbr_next;
    logic [ADDR_W-1:0]  out_idx_reg, out_idx_next;
    logic [WORD_W-1:0]  link_reg, link_next;
    logic [WORD_W-1:0]  cur_reg, cur_next;
    logic [WORD_W-1:0]  sum_reg, sum_next;
    logic [ROUND_W-1:0] rounds_reg, rounds_next;
    logic               byp_reg, byp_next;
    logic [WORD_W-1:0]  byp_data_reg, byp_data_next;
    logic               pend_last_reg, pend_last_next;
    logic [WORD_W-1:0]  m_word_reg, m_word_next;
    logic               m_last_reg, m_last_next;

    logic [CNT_W-1:0]   count_m1;
    logic [ADDR_W-1:0]  last_addr;
    logic               single;
    logic               has_room;
    logic               issue;
    logic               round_end;
    logic [WORD_W-1:0]  fetched;
    logic [WORD_W-1:0]  z_w, y_w, mix_w, new_w;
    logic [1:0]         key_sel;

    function automatic logic [ADDR_W-1:0] adv(input logic [ADDR_W-1:0] x,
                                              input logic [ADDR_W-1:0] lst,
                                              input logic              dn);
        logic [ADDR_W-1:0] r;
        if (dn) r = (x == '0) ? lst : x - ADDR_W'(1);
        else    r = (x == lst) ? '0 : x + ADDR_W'(1);
        return r;
    endfunction

    assign count_m1  = count_reg - CNT_W'(1);
    assign last_addr = count_m1[ADDR_W-1:0];
    assign single    = (last_addr == '0);
    assign has_room  = (count_reg < CNT_W'(MAX_WORDS));

    // Step arithmetic: neighbor word arrives from memory or from the bypass
    assign fetched   = byp_reg ? byp_data_reg : rd_data_reg;
    assign z_w       = decrypt ? fetched : link_reg;
    assign y_w       = decrypt ? link_reg : fetched;
    assign key_sel   = 2'(pos_reg) ^ sum_reg[3:2];
    assign mix_w     = mx(z_w, y_w, sum_reg, key[key_sel]);
    assign new_w     = decrypt ? (cur_reg - mix_w) : (cur_reg + mix_w);
    assign round_end = decrypt ? (pos_reg == '0) : (pos_reg == last_addr);

    assign issue = (cmd.op == DP_DRAIN) && !pend_reg && (!m_valid_reg || m_ready);

    always_comb begin
        count_next    = count_reg;
        pos_next      = pos_reg;
        nbr_next      = nbr_reg;
        out_idx_next  = out_idx_reg;
        link_next     = link_reg;
        cur_next      = cur_reg;
        sum_next      = sum_reg;
        rounds_next   = rounds_reg;
        byp_next      = 1'b0;
        byp_data_next = byp_data_reg;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = count_reg[ADDR_W-1:0];
        wr_data       = in_word;

        if (cmd.store && has_room) begin
            wr_en      = 1'b1;
            count_next = count_reg + CNT_W'(1);
        end

        unique case (cmd.op)
            DP_IDLE: begin
            end
            DP_INIT_A: begin
                rounds_next  = rounds_for(LEN_W'(count_reg));
                out_idx_next = '0;
                rd_addr      = decrypt ? '0 : last_addr;
                pos_next     = decrypt ? last_addr : '0;
                nbr_next     = decrypt ? adv(last_addr, last_addr, 1'b1)
                                       : adv('0, last_addr, 1'b0);
            end
            DP_INIT_B: begin
                link_next = rd_data_reg;
                rd_addr   = decrypt ? last_addr : '0;
                sum_next  = decrypt ? (WORD_W'(rounds_reg) * TEA_DELTA) : TEA_DELTA;
            end
            DP_INIT_C: begin
                cur_next = rd_data_reg;
                rd_addr  = nbr_reg;
            end
            DP_STEP: begin
                wr_en         = 1'b1;
                wr_addr       = pos_reg;
                wr_data       = new_w;
                link_next     = new_w;
                cur_next      = single ? new_w : fetched;
                pos_next      = adv(pos_reg, last_addr, decrypt);
                nbr_next      = adv(nbr_reg, last_addr, decrypt);
                rd_addr       = nbr_next;
                // forward the word being written if it is read back now
                byp_next      = (nbr_next == pos_reg);
                byp_data_next = new_w;
                if (round_end) begin
                    rounds_next = rounds_reg - ROUND_W'(1);
                    sum_next    = decrypt ? (sum_reg - TEA_DELTA) : (sum_reg + TEA_DELTA);
                end
            end
            DP_DRAIN: begin
                rd_addr = out_idx_reg;
                if (issue) begin
                    out_idx_next = out_idx_reg + ADDR_W'(1);
                    if (out_idx_reg == last_addr) count_next = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: load the word read last cycle, drop it on transfer
    always_comb begin
        pend_next      = issue;
        pend_last_next = issue ? (out_idx_reg == last_addr) : pend_last_reg;
        m_valid_next   = m_valid_reg;
        m_word_next    = m_word_reg;
        m_last_next    = m_last_reg;
        if (pend_reg) begin
            m_valid_next = 1'b1;
            m_word_next  = rd_data_reg;
            m_last_next  = pend_last_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            byp_reg     <= 1'b0;
        end else begin
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            byp_reg     <= byp_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg       <= pos_next;
        nbr_reg       <= nbr_next;
        out_idx_reg   <= out_idx_next;
        link_reg      <= link_next;
        cur_reg       <= cur_next;
        sum_reg       <= sum_next;
        rounds_reg    <= rounds_next;
        byp_data_reg  <= byp_data_next;
        pend_last_reg <= pend_last_next;
        m_word_reg    <= m_word_next;
        m_last_reg    <= m_last_next;
    end

    assign stat.steps_done = (cmd.op == DP_STEP) && round_end && (rounds_reg == ROUND_W'(1));
    assign stat.drain_done = issue && (out_idx_reg == last_addr);

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;
    assign m_last  = m_last_reg;

endmodule

`default_nettype wire

// File: rtl/core/xxtea_block_cipher_unit.sv
// XXTEA whole-block cipher unit: configuration registers, controller and datapath.
//
// Usage: write the four key words and the mode (0 encrypt, 1 decrypt) through
// cfg_wr_en / cfg_index / cfg_data. Stream a block in on the s_ channel, one
// 32-bit word per transfer, the final word with s_is_last set. Words beyond
// MAX_WORDS are dropped. Once the final word is in, the block is processed in
// place and the words leave on the m_ channel in order, the final one marked
// with m_result_last.
// For an n-word block: after the setup states, processing performs
// n * (6 + 52/n) word updates at one word update per cycle, bound by the
// single read and write port of the word buffer. Each result word is read
// from the buffer, then loaded into the output register, before the next is read.
// s_ready stays low from the final word until the last result word has been
// read from the buffer; the next block may load while that word waits.
// A stalled receiver holds m_valid and the output word; the drain waits.
// Reset clears keys, mode, word count and the output valid; the block is
// ready for a new block right after reset.
`default_nettype none

module xxtea_block_cipher_unit import xxt_pkg::*; #(
    parameter int MAX_WORDS = DEFAULT_MAX_WORDS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [WORD_W-1:0]    s_data_word,
    input  wire logic                 s_is_last,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [WORD_W-1:0]         m_result_word,
    output logic                      m_result_last
);

    logic [3:0][WORD_W-1:0] key_reg;
    logic                   mode_reg;
    dp_cmd_t                cmd;
    dp_stat_t               stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg  <= '0;
            mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_KEY0: key_reg[0] <= cfg_data;
                REG_KEY1: key_reg[1] <= cfg_data;
                REG_KEY2: key_reg[2] <= cfg_data;
                REG_KEY3: key_reg[3] <= cfg_data;
                REG_MODE: mode_reg   <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    xxt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_is_last (s_is_last),
        .s_ready   (s_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    xxt_datapath #(
        .MAX_WORDS (MAX_WORDS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .in_word (s_data_word),
        .key     (key_reg),
        .decrypt (mode_reg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_result_word),
        .m_last  (m_result_last)
    );

endmodule

`default_nettype wire
